// ===== sv/dcm_pkg.sv =====
// ---------------------------------------------------------------------------
// dcm_pkg: shared types and constants of the DC motor RK4 step
// Payload words of the request and response channels and the CSR indexes.
// ---------------------------------------------------------------------------
package dcm_pkg;

   localparam int IN_BITS  = 32;
   localparam int CSR_BITS = 31;
   localparam int IDX_BITS = 3;

   typedef struct packed {
      logic signed [IN_BITS-1:0] current_now;
      logic signed [IN_BITS-1:0] speed_now;
      logic                      switch_on;
   } req_word_type;

   typedef struct packed {
      logic signed [IN_BITS-1:0] current_next;
      logic signed [IN_BITS-1:0] speed_next;
   } rsp_word_type;

   localparam logic [IDX_BITS-1:0] CSR_STEP_SIZE      = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_SUPPLY_VOLTAGE = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_FLUX_LINKAGE   = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_WINDING_RES    = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_INV_INDUCTANCE = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_FRICTION       = 3'd5;
   localparam logic [IDX_BITS-1:0] CSR_INV_INERTIA    = 3'd6;

   localparam logic [CSR_BITS-1:0] STEP_SIZE_RESET = 31'd66;

endpackage

// ===== sv/dcm_mul.sv =====
// ---------------------------------------------------------------------------
// dcm_mul: registered saturating fixed-point multiplier
// Exact product, shifted right by FRAC_BITS with magnitude truncation, then
// saturated to the signed word; result registered when enable is high.
// ---------------------------------------------------------------------------
module dcm_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] p_ff
);

   localparam int W = WORD_BITS;

   logic                   neg;
   logic [W-1:0]           mag_a;
   logic [W-1:0]           mag_b;
   logic [2*W-1:0]         prod;
   logic [2*W-1:0]         quot;
   logic                   over;
   logic signed [W-1:0]    p_in;

   // take magnitudes, multiply, truncate and saturate
   always_comb begin
      neg   = a[W-1] ^ b[W-1];
      mag_a = a[W-1] ? W'(-a) : W'(a);
      mag_b = b[W-1] ? W'(-b) : W'(b);
      prod  = (2*W)'(mag_a) * (2*W)'(mag_b);
      quot  = prod >> FRAC_BITS;
      over  = |quot[2*W-1:W-1];
      if (over) begin
         p_in = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (neg) begin
         p_in = -$signed(quot[W-1:0]);
      end else begin
         p_in = $signed(quot[W-1:0]);
      end
   end

   // hold the product while stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
      end
   end

endmodule

// ===== sv/dcm_cell.sv =====
// ---------------------------------------------------------------------------
// dcm_cell: one Runge-Kutta stage of the motor model
// Forms the evaluation point from the previous slope, evaluates both motor
// derivatives and folds the previous slope into the running weighted sum.
// It takes one word per cycle while enable is high.
// ---------------------------------------------------------------------------
module dcm_cell #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16,
   parameter bit FIRST     = 1'b0,  // evaluate at the start point itself
   parameter bit FULL      = 1'b0,  // offset by a whole step, else half
   parameter int ACC_MODE  = 0      // 0 none, 1 load slope, 2 add twice slope
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic signed [WORD_BITS-1:0] in_x0i,
   input  logic signed [WORD_BITS-1:0] in_x0w,
   input  logic signed [WORD_BITS-1:0] in_ki,
   input  logic signed [WORD_BITS-1:0] in_kw,
   input  logic signed [WORD_BITS-1:0] in_acci,
   input  logic signed [WORD_BITS-1:0] in_accw,
   input  logic signed [WORD_BITS-1:0] in_uterm,
   input  logic signed [WORD_BITS-1:0] reg_h,
   input  logic signed [WORD_BITS-1:0] reg_flux,
   input  logic signed [WORD_BITS-1:0] reg_r,
   input  logic signed [WORD_BITS-1:0] reg_invl,
   input  logic signed [WORD_BITS-1:0] reg_b,
   input  logic signed [WORD_BITS-1:0] reg_invj,
   output logic                        out_valid,
   output logic signed [WORD_BITS-1:0] out_x0i,
   output logic signed [WORD_BITS-1:0] out_x0w,
   output logic signed [WORD_BITS-1:0] out_ki,
   output logic signed [WORD_BITS-1:0] out_kw,
   output logic signed [WORD_BITS-1:0] out_acci,
   output logic signed [WORD_BITS-1:0] out_accw,
   output logic signed [WORD_BITS-1:0] out_uterm
);

   localparam int W     = WORD_BITS;
   localparam int DEPTH = 5;

   typedef struct packed {
      logic signed [W-1:0] x0i;
      logic signed [W-1:0] x0w;
      logic signed [W-1:0] acci;
      logic signed [W-1:0] accw;
      logic signed [W-1:0] uterm;
   } carry_type;

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y);
      logic signed [W:0] s;
      s = (W+1)'(x) + (W+1)'(y);
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y);
      logic signed [W:0] s;
      s = (W+1)'(x) - (W+1)'(y);
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   logic [DEPTH-1:0]    valid_ff;
   carry_type           carry_ff [DEPTH];
   carry_type           carry_in;
   logic signed [W-1:0] h_step;
   logic signed [W-1:0] mi;
   logic signed [W-1:0] mw;
   logic signed [W-1:0] pi_ff;
   logic signed [W-1:0] pw_ff;
   logic signed [W-1:0] pi_in;
   logic signed [W-1:0] pw_in;
   logic signed [W-1:0] m_wflux;
   logic signed [W-1:0] m_ri;
   logic signed [W-1:0] m_fluxi;
   logic signed [W-1:0] m_bw;
   logic signed [W-1:0] vi_ff;
   logic signed [W-1:0] vw_ff;
   logic signed [W-1:0] vi_in;
   logic signed [W-1:0] vw_in;

   // step offset: whole or half step
   assign h_step = FULL ? reg_h : (reg_h >>> 1);

   // fold the incoming slope into the weighted sum
   always_comb begin
      carry_in.x0i   = in_x0i;
      carry_in.x0w   = in_x0w;
      carry_in.uterm = in_uterm;
      case (ACC_MODE)
         1: begin
            carry_in.acci = in_ki;
            carry_in.accw = in_kw;
         end
         2: begin
            carry_in.acci = sat_add(in_acci, sat_add(in_ki, in_ki));
            carry_in.accw = sat_add(in_accw, sat_add(in_kw, in_kw));
         end
         default: begin
            carry_in.acci = in_acci;
            carry_in.accw = in_accw;
         end
      endcase
   end

   // advance the side band and the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         carry_ff[0] <= carry_in;
         for (int j = 1; j < DEPTH; j++) begin
            carry_ff[j] <= carry_ff[j-1];
         end
      end
   end

   // offset products h*k
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_oi (
      .clock(clock), .enable(enable), .a(h_step), .b(in_ki), .p_ff(mi));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ow (
      .clock(clock), .enable(enable), .a(h_step), .b(in_kw), .p_ff(mw));

   // evaluation point
   assign pi_in = FIRST ? carry_ff[0].x0i : sat_add(carry_ff[0].x0i, mi);
   assign pw_in = FIRST ? carry_ff[0].x0w : sat_add(carry_ff[0].x0w, mw);

   always_ff @(posedge clock) begin
      if (enable) begin
         pi_ff <= pi_in;
         pw_ff <= pw_in;
      end
   end

   // motor products
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_wf (
      .clock(clock), .enable(enable), .a(pw_ff), .b(reg_flux), .p_ff(m_wflux));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ri (
      .clock(clock), .enable(enable), .a(reg_r), .b(pi_ff), .p_ff(m_ri));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_fi (
      .clock(clock), .enable(enable), .a(reg_flux), .b(pi_ff), .p_ff(m_fluxi));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_bw (
      .clock(clock), .enable(enable), .a(reg_b), .b(pw_ff), .p_ff(m_bw));

   // voltage and torque balances
   assign vi_in = sat_sub(sat_sub(carry_ff[2].uterm, m_wflux), m_ri);
   assign vw_in = sat_sub(m_fluxi, m_bw);

   always_ff @(posedge clock) begin
      if (enable) begin
         vi_ff <= vi_in;
         vw_ff <= vw_in;
      end
   end

   // scale by the reciprocals to get the slopes
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ki (
      .clock(clock), .enable(enable), .a(vi_ff), .b(reg_invl), .p_ff(out_ki));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_kw (
      .clock(clock), .enable(enable), .a(vw_ff), .b(reg_invj), .p_ff(out_kw));

   assign out_valid = valid_ff[DEPTH-1];
   assign out_x0i   = carry_ff[DEPTH-1].x0i;
   assign out_x0w   = carry_ff[DEPTH-1].x0w;
   assign out_acci  = carry_ff[DEPTH-1].acci;
   assign out_accw  = carry_ff[DEPTH-1].accw;
   assign out_uterm = carry_ff[DEPTH-1].uterm;

endmodule

// ===== sv/dcm_tail.sv =====
// ---------------------------------------------------------------------------
// dcm_tail: final update of the RK4 step
// Adds the last slope, divides the sum by six, scales by h, updates the
// state, applies the current clamp and saturates into the response word.
// ---------------------------------------------------------------------------
module dcm_tail #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic signed [WORD_BITS-1:0] in_x0i,
   input  logic signed [WORD_BITS-1:0] in_x0w,
   input  logic signed [WORD_BITS-1:0] in_ki,
   input  logic signed [WORD_BITS-1:0] in_kw,
   input  logic signed [WORD_BITS-1:0] in_acci,
   input  logic signed [WORD_BITS-1:0] in_accw,
   input  logic signed [WORD_BITS-1:0] reg_h,
   input  logic signed [WORD_BITS-1:0] reg_u,
   input  logic signed [WORD_BITS-1:0] reg_flux,
   output logic                        out_valid_ff,
   output dcm_pkg::rsp_word_type       out_word_ff
);

   localparam int W     = WORD_BITS;
   localparam int WX    = (W > dcm_pkg::IN_BITS) ? W : dcm_pkg::IN_BITS;
   localparam int DEPTH = 5;
   localparam logic [W+1:0] POW   = {{(W+1){1'b0}}, 1'b1} << (W+1);
   localparam logic [W+1:0] MAGIC = (POW + (W+2)'(2)) / (W+2)'(3);

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y);
      logic signed [W:0] s;
      s = (W+1)'(x) + (W+1)'(y);
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   // divide by six, truncating toward zero: halve, then multiply by 1/3
   function automatic logic signed [W-1:0] div6(input logic signed [W-1:0] s);
      logic [W-1:0]   mag;
      logic [W-1:0]   half;
      logic [2*W-1:0] prod;
      logic [W-1:0]   q;
      mag  = s[W-1] ? W'(-s) : W'(s);
      half = mag >> 1;
      prod = (2*W)'(half) * (2*W)'(MAGIC[W-1:0]);
      q    = W'(prod >> (W+1));
      return s[W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [dcm_pkg::IN_BITS-1:0] to_out(
      input logic signed [W-1:0] v);
      logic signed [WX:0] e;
      logic signed [WX:0] mx;
      logic signed [WX:0] mn;
      e  = (WX+1)'(v);
      mx = (WX+1)'($signed({1'b0, {(dcm_pkg::IN_BITS-1){1'b1}}}));
      mn = (WX+1)'($signed({1'b1, {(dcm_pkg::IN_BITS-1){1'b0}}}));
      if (e > mx) begin
         e = mx;
      end else if (e < mn) begin
         e = mn;
      end
      return e[dcm_pkg::IN_BITS-1:0];
   endfunction

   logic [DEPTH-1:0]    valid_ff;
   logic signed [W-1:0] x0i_ff [3];
   logic signed [W-1:0] x0w_ff [3];
   logic signed [W-1:0] si_ff;
   logic signed [W-1:0] sw_ff;
   logic signed [W-1:0] qi_ff;
   logic signed [W-1:0] qw_ff;
   logic signed [W-1:0] di;
   logic signed [W-1:0] dw;
   logic signed [W-1:0] i1_ff;
   logic signed [W-1:0] w1_ff;
   logic signed [W-1:0] i1d_ff;
   logic signed [W-1:0] w1d_ff;
   logic signed [W-1:0] wflux;
   dcm_pkg::rsp_word_type out_word_in;

   // advance the valid bits and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= {valid_ff[DEPTH-2:0], in_valid};
         out_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   // last slope into the sum, then divide by six
   always_ff @(posedge clock) begin
      if (enable) begin
         si_ff     <= sat_add(in_acci, in_ki);
         sw_ff     <= sat_add(in_accw, in_kw);
         qi_ff     <= div6(si_ff);
         qw_ff     <= div6(sw_ff);
         x0i_ff[0] <= in_x0i;
         x0w_ff[0] <= in_x0w;
         for (int j = 1; j < 3; j++) begin
            x0i_ff[j] <= x0i_ff[j-1];
            x0w_ff[j] <= x0w_ff[j-1];
         end
      end
   end

   // scale the mean slope by the step
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_hi (
      .clock(clock), .enable(enable), .a(reg_h), .b(qi_ff), .p_ff(di));
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_hw (
      .clock(clock), .enable(enable), .a(reg_h), .b(qw_ff), .p_ff(dw));

   // update the state
   always_ff @(posedge clock) begin
      if (enable) begin
         i1_ff  <= sat_add(x0i_ff[2], di);
         w1_ff  <= sat_add(x0w_ff[2], dw);
         i1d_ff <= i1_ff;
         w1d_ff <= w1_ff;
      end
   end

   // back EMF of the new speed for the clamp test
   dcm_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_emf (
      .clock(clock), .enable(enable), .a(w1_ff), .b(reg_flux), .p_ff(wflux));

   // clamp a negative current that the supply can no longer drive
   always_comb begin
      if (i1d_ff[W-1] && (wflux <= reg_u)) begin
         out_word_in.current_next = '0;
      end else begin
         out_word_in.current_next = to_out(i1d_ff);
      end
      out_word_in.speed_next = to_out(w1d_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

// ===== sv/dc_motor_rk4_step.sv =====
// ---------------------------------------------------------------------------
// dc_motor_rk4_step: one fourth-order Runge-Kutta step of a DC motor
// Pipelined fixed-point integrator of current and speed with a CSR port.
// ---------------------------------------------------------------------------
// The block accepts one request word per clock while req_stall is low and
// returns one response word per request, in order: each passes four RK stage
// cells and a final update, built from registered saturating multipliers
// between the adds. Whenever the response register is full and stalled the
// whole pipeline holds and req_stall is raised. The CSR port is always ready;
// write it only while no request is in flight.
// ---------------------------------------------------------------------------
module dc_motor_rk4_step #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dcm_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dcm_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dcm_pkg::IDX_BITS-1:0]        csr_index,
   input  logic [dcm_pkg::CSR_BITS-1:0]        csr_data
);

   localparam int W     = WORD_BITS;
   localparam int WX    = (W > dcm_pkg::IN_BITS) ? W : dcm_pkg::IN_BITS;
   localparam int CELLS = 4;

   // bring a 32-bit signed value into the word, saturating
   function automatic logic signed [W-1:0] to_word(
      input logic signed [dcm_pkg::IN_BITS-1:0] v);
      logic signed [WX:0] e;
      logic signed [WX:0] mx;
      logic signed [WX:0] mn;
      e  = (WX+1)'(v);
      mx = (WX+1)'($signed({1'b0, {(W-1){1'b1}}}));
      mn = (WX+1)'($signed({1'b1, {(W-1){1'b0}}}));
      if (e > mx) begin
         e = mx;
      end else if (e < mn) begin
         e = mn;
      end
      return e[W-1:0];
   endfunction

   logic signed [W-1:0] h_ff, u_ff, flux_ff, r_ff, invl_ff, b_ff, invj_ff;
   logic                enable;
   logic signed [W-1:0] in_i;
   logic signed [W-1:0] in_w;
   logic signed [W-1:0] in_u;
   logic signed [W-1:0] csr_word;

   logic                c_valid [CELLS+1];
   logic signed [W-1:0] c_x0i   [CELLS+1];
   logic signed [W-1:0] c_x0w   [CELLS+1];
   logic signed [W-1:0] c_ki    [CELLS+1];
   logic signed [W-1:0] c_kw    [CELLS+1];
   logic signed [W-1:0] c_acci  [CELLS+1];
   logic signed [W-1:0] c_accw  [CELLS+1];
   logic signed [W-1:0] c_uterm [CELLS+1];

   // advance everything unless a finished word is stalled
   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;
   assign csr_ready = 1'b1;

   // configuration registers
   assign csr_word = to_word($signed({1'b0, csr_data}));

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= to_word($signed({1'b0, dcm_pkg::STEP_SIZE_RESET}));
         u_ff    <= '0;
         flux_ff <= '0;
         r_ff    <= '0;
         invl_ff <= '0;
         b_ff    <= '0;
         invj_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dcm_pkg::CSR_STEP_SIZE:      h_ff    <= csr_word;
            dcm_pkg::CSR_SUPPLY_VOLTAGE: u_ff    <= csr_word;
            dcm_pkg::CSR_FLUX_LINKAGE:   flux_ff <= csr_word;
            dcm_pkg::CSR_WINDING_RES:    r_ff    <= csr_word;
            dcm_pkg::CSR_INV_INDUCTANCE: invl_ff <= csr_word;
            dcm_pkg::CSR_FRICTION:       b_ff    <= csr_word;
            dcm_pkg::CSR_INV_INERTIA:    invj_ff <= csr_word;
            default: begin
            end
         endcase
      end
   end

   // request word into the first cell
   assign in_i = to_word(req_word.current_now);
   assign in_w = to_word(req_word.speed_now);
   assign in_u = req_word.switch_on ? u_ff : '0;

   assign c_valid[0] = req_valid;
   assign c_x0i[0]   = in_i;
   assign c_x0w[0]   = in_w;
   assign c_ki[0]    = '0;
   assign c_kw[0]    = '0;
   assign c_acci[0]  = '0;
   assign c_accw[0]  = '0;
   assign c_uterm[0] = in_u;

   // row of RK stage cells
   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      dcm_cell #(
         .WORD_BITS(W),
         .FRAC_BITS(FRAC_BITS),
         .FIRST(g == 0),
         .FULL(g == CELLS - 1),
         .ACC_MODE((g == 0) ? 0 : ((g == 1) ? 1 : 2))
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .enable(enable),
         .in_valid(c_valid[g]),
         .in_x0i(c_x0i[g]),
         .in_x0w(c_x0w[g]),
         .in_ki(c_ki[g]),
         .in_kw(c_kw[g]),
         .in_acci(c_acci[g]),
         .in_accw(c_accw[g]),
         .in_uterm(c_uterm[g]),
         .reg_h(h_ff),
         .reg_flux(flux_ff),
         .reg_r(r_ff),
         .reg_invl(invl_ff),
         .reg_b(b_ff),
         .reg_invj(invj_ff),
         .out_valid(c_valid[g+1]),
         .out_x0i(c_x0i[g+1]),
         .out_x0w(c_x0w[g+1]),
         .out_ki(c_ki[g+1]),
         .out_kw(c_kw[g+1]),
         .out_acci(c_acci[g+1]),
         .out_accw(c_accw[g+1]),
         .out_uterm(c_uterm[g+1])
      );
   end

   // final update and response register
   dcm_tail #(
      .WORD_BITS(W),
      .FRAC_BITS(FRAC_BITS)
   ) u_tail (
      .clock(clock),
      .reset(reset),
      .enable(enable),
      .in_valid(c_valid[CELLS]),
      .in_x0i(c_x0i[CELLS]),
      .in_x0w(c_x0w[CELLS]),
      .in_ki(c_ki[CELLS]),
      .in_kw(c_kw[CELLS]),
      .in_acci(c_acci[CELLS]),
      .in_accw(c_accw[CELLS]),
      .reg_h(h_ff),
      .reg_u(u_ff),
      .reg_flux(flux_ff),
      .out_valid_ff(rsp_valid),
      .out_word_ff(rsp_word)
   );

endmodule
